// File: rtl/utf16_to_utf8_encoder_defines.svh
// Assertion macros used by the checker of the UTF-16 to UTF-8 encoder.
// Both expect signals named clk and arst_n in the scope where they are used.
`ifndef UTF16_TO_UTF8_ENCODER_DEFINES_SVH
`define UTF16_TO_UTF8_ENCODER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define UTE_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset
`define UTE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: rtl/ute_pkg.sv
`timescale 1ns / 1ps

package ute_pkg;

	// Surrogate classification
	localparam logic [15:0] SURR_MASK = 16'hFC00;
	localparam logic [15:0] HIGH_TAG  = 16'hD800;
	localparam logic [15:0] LOW_TAG   = 16'hDC00;

	// Range limits for one- and two-byte forms
	localparam logic [15:0] ONE_BYTE_MAX = 16'h007F;
	localparam logic [15:0] TWO_BYTE_MAX = 16'h07FF;

	// Plane offset added to the high surrogate bits of a pair
	localparam logic [10:0] PLANE_OFS = 11'h040;

	// Lead and continuation byte tags
	localparam logic [7:0] LEAD2 = 8'hC0;
	localparam logic [7:0] LEAD3 = 8'hE0;
	localparam logic [7:0] LEAD4 = 8'hF0;
	localparam logic [7:0] CONT  = 8'h80;

	localparam int unsigned MAX_BYTES = 6;

	// One encoded request: up to six bytes, first byte in slot 0
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [2:0]                cnt;
		logic                      done;
	} job_t;

endpackage

// File: rtl/ute_front.sv
`timescale 1ns / 1ps

module ute_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [15:0]   code_unit,
	input  logic          end_of_string,
	input  logic          q_full,
	output logic          job_push,
	output ute_pkg::job_t job
);
	import ute_pkg::*;

	logic        held_valid_q;
	logic [9:0]  held_bits_q;
	logic        accept;
	logic        is_high;
	logic        is_low;
	logic        pairing;
	logic        hold_new;
	logic [10:0] plane;
	logic [15:0] flush_unit;
	logic [2:0][7:0] fb;
	logic [2:0][7:0] nb;
	logic [2:0]  ncnt;

	assign accept = push && !q_full;
	assign full   = q_full;

	assign is_high = (code_unit & SURR_MASK) == HIGH_TAG;
	assign is_low  = (code_unit & SURR_MASK) == LOW_TAG;
	assign pairing = held_valid_q && is_low;
	assign plane   = {1'b0, held_bits_q} + PLANE_OFS;
	assign flush_unit = {6'b110110, held_bits_q};

	// Flush bytes for an unpaired held high surrogate
	assign fb[0] = LEAD3 | {4'h0, flush_unit[15:12]};
	assign fb[1] = CONT  | {2'b00, flush_unit[11:6]};
	assign fb[2] = CONT  | {2'b00, flush_unit[5:0]};

	// Classify and encode the new unit on its own
	always_comb begin
		nb       = '0;
		ncnt     = 3'd0;
		hold_new = 1'b0;
		if (code_unit <= ONE_BYTE_MAX) begin
			nb[0] = code_unit[7:0];
			ncnt  = 3'd1;
		end else if (code_unit <= TWO_BYTE_MAX) begin
			nb[0] = LEAD2 | {3'b000, code_unit[10:6]};
			nb[1] = CONT  | {2'b00, code_unit[5:0]};
			ncnt  = 3'd2;
		end else if (is_high && !end_of_string) begin
			hold_new = 1'b1;
		end else begin
			nb[0] = LEAD3 | {4'h0, code_unit[15:12]};
			nb[1] = CONT  | {2'b00, code_unit[11:6]};
			nb[2] = CONT  | {2'b00, code_unit[5:0]};
			ncnt  = 3'd3;
		end
	end

	// Assemble the request: a pair, or an optional flush then the new unit
	always_comb begin
		job       = '0;
		job.done  = end_of_string;
		if (pairing) begin
			job.bytes[0] = LEAD4 | {5'b00000, plane[10:8]};
			job.bytes[1] = CONT  | {2'b00, plane[7:2]};
			job.bytes[2] = CONT  | {2'b00, plane[1:0], code_unit[9:6]};
			job.bytes[3] = CONT  | {2'b00, code_unit[5:0]};
			job.cnt      = 3'd4;
		end else if (held_valid_q) begin
			job.bytes[0] = fb[0];
			job.bytes[1] = fb[1];
			job.bytes[2] = fb[2];
			job.bytes[3] = nb[0];
			job.bytes[4] = nb[1];
			job.bytes[5] = nb[2];
			job.cnt      = 3'd3 + ncnt;
		end else begin
			job.bytes[0] = nb[0];
			job.bytes[1] = nb[1];
			job.bytes[2] = nb[2];
			job.cnt      = ncnt;
		end
	end

	assign job_push = accept && (job.cnt != 3'd0);

	// Held high surrogate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			held_bits_q  <= '0;
		end else if (accept) begin
			held_valid_q <= !pairing && hold_new;
			held_bits_q  <= (!pairing && hold_new) ? code_unit[9:0] : 10'h000;
		end
	end

endmodule

// File: rtl/ute_queue.sv
`timescale 1ns / 1ps

module ute_queue #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  ute_pkg::job_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output ute_pkg::job_t rd_data,
	output logic          empty
);
	import ute_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full    = count_q == CW'(DEPTH);
	assign empty   = count_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Request storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// File: rtl/ute_back.sv
`timescale 1ns / 1ps

module ute_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  ute_pkg::job_t q_data,
	output logic          q_pop,
	output logic [7:0]    utf8_byte,
	output logic          last_of_run,
	output logic          string_done,
	output logic          empty,
	input  logic          pop
);
	import ute_pkg::*;

	job_t       cur_q;
	logic       cur_valid_q;
	logic [2:0] idx_q;
	logic       at_last;
	logic       take;

	assign at_last = idx_q == (cur_q.cnt - 3'd1);
	assign take    = cur_valid_q && pop;

	// Load the next request when idle or when its last byte leaves
	assign q_pop = !q_empty && (!cur_valid_q || (take && at_last));

	assign empty       = !cur_valid_q;
	assign utf8_byte   = cur_q.bytes[idx_q];
	assign last_of_run = at_last;
	assign string_done = at_last && cur_q.done;

	// Request payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
	end

	// Byte sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (q_pop) begin
			cur_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (take) begin
			if (at_last) begin
				cur_valid_q <= 1'b0;
				idx_q       <= '0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

endmodule

// File: rtl/utf16_to_utf8_encoder.sv
`timescale 1ns / 1ps
// UTF-16 to UTF-8 encoder.
// Input queue side: code_unit and end_of_string are taken at a clock edge with
// push high and full low. Output queue side: utf8_byte, last_of_run and
// string_done show the oldest byte while empty is low; pop takes it.
// A front stage classifies each unit, holds a high surrogate until the next
// unit arrives, and writes a request of one to six bytes into a queue of
// QUEUE_DEPTH entries. A back stage sends those bytes one per cycle while pop
// is high. A request is stored in the queue and then loaded into the back
// stage before its first byte shows; a unit held as a high surrogate writes
// no request.
// last_of_run marks the final byte of each request, string_done the final byte of
// a unit with end_of_string set.
// Reset clears the held surrogate, the queue and the output; empty goes high.
// If the receiver stalls, the shown byte holds, the queue fills, and full
// rises until bytes are taken again.

module utf16_to_utf8_encoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [15:0] code_unit,
	input  logic        end_of_string,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  utf8_byte,
	output logic        last_of_run,
	output logic        string_done
);
	import ute_pkg::*;

	job_t wr_job;
	job_t rd_job;
	logic job_push;
	logic q_full;
	logic q_empty;
	logic q_pop;

	ute_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.code_unit     (code_unit),
		.end_of_string (end_of_string),
		.q_full        (q_full),
		.job_push      (job_push),
		.job           (wr_job)
	);

	ute_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_data (wr_job),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (rd_job),
		.empty   (q_empty)
	);

	ute_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_data      (rd_job),
		.q_pop       (q_pop),
		.utf8_byte   (utf8_byte),
		.last_of_run (last_of_run),
		.string_done (string_done),
		.empty       (empty),
		.pop         (pop)
	);

endmodule

// File: rtl/ute_checker.sv
`timescale 1ns / 1ps
`include "utf16_to_utf8_encoder_defines.svh"

module ute_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [7:0]  utf8_byte,
	input logic        last_of_run,
	input logic        string_done
);

	// End of string only on the last byte of a unit
	`UTE_ASSERT_SAME(a_done_on_last, !empty && string_done, last_of_run)

	// Every byte before the last one of a unit is a lead or continuation byte
	`UTE_ASSERT_SAME(a_multi_top_bit, !empty && !last_of_run, utf8_byte[7])

	// Once a unit's bytes start, they follow without gaps
	`UTE_ASSERT_NEXT(a_run_unbroken, !empty && pop && !last_of_run, !empty)

	// A stalled byte stays put
	`UTE_ASSERT_NEXT(a_stall_holds, !empty && !pop,
		!empty && $stable(utf8_byte) && $stable(last_of_run))

endmodule

bind utf16_to_utf8_encoder ute_checker u_chk (.*);
